>>> design/rsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the radix string converter
// Payload structs, status codes, register indexes, character codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam int DIGIT_W   = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_BASE = 1'b1;

   localparam logic [CFG_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [CFG_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [CFG_W-1:0] BASE_RESET = 6'd10;

   // digit value given to a character that is not alphanumeric
   localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 6'd36;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [7:0] digit_char;
      logic       end_of_number;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_digit;
      logic [1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;       // capture item, product and digit value
      logic fold;         // add digit into accumulator, update flags
      logic div_load;     // start division of the accumulator
      logic div_restart;  // start division of the previous quotient
      logic div_step;     // one restoring division step
      logic store_digit;  // write remainder to digit store
      logic rd_issue;     // read digit store at the read index
      logic push_digit;   // load output register with a digit
      logic push_error;   // load output register with an error item
      logic clear;        // clear number state
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic end_flag;
      logic bad_seen;
      logic ovf_seen;
      logic div_last;
      logic quot_zero;
      logic count_full;
      logic rd_last;
      logic out_free;
   } stat_type;

endpackage

>>> design/rsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_ctrl: sequencing controller of the radix string converter
// Steps each character through capture and fold, then runs the division,
// digit store and emission sequence at the end of a number.
// ----------------------------------------------------------------------------
module rsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsc_pkg::stat_type stat,
   output rsc_pkg::cmd_type  cmd
);
   import rsc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FOLD  = 8'b0000_0010,
      ST_CHECK = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_STORE = 8'b0001_0000,
      ST_READ  = 8'b0010_0000,
      ST_PUSH  = 8'b0100_0000,
      ST_ERROR = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = stat.end_flag ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            if (stat.bad_seen || stat.ovf_seen) begin
               state_in = ST_ERROR;
            end else begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_digit = 1'b1;
            if (stat.quot_zero) begin
               state_in = ST_READ;
            end else if (stat.count_full) begin
               state_in = ST_ERROR;
            end else begin
               cmd.div_restart = 1'b1;
               state_in        = ST_DIV;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_PUSH;
         end
         ST_PUSH: begin
            if (stat.out_free) begin
               cmd.push_digit = 1'b1;
               if (stat.rd_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ERROR: begin
            if (stat.out_free) begin
               cmd.push_error = 1'b1;
               cmd.clear      = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_accept_then_fold: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_FOLD)
      else $error("accepted item not followed by fold");

   a_no_push_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_digit || cmd.push_error) |-> stat.out_free)
      else $error("push while output register is blocked");
`endif

endmodule

>>> design/rsc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_dp: datapath of the radix string converter
// Base registers, multiply-add accumulator, restoring radix divider,
// digit store and the registered result output.
// ----------------------------------------------------------------------------
module rsc_dp #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rsc_pkg::CFG_W-1:0]         csr_wdata,
   input  rsc_pkg::req_type                  req_data,
   input  rsc_pkg::cmd_type                  cmd,
   output rsc_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   output rsc_pkg::rsp_type                  rsp_data,
   input  logic                              rsp_stall
);
   import rsc_pkg::*;

   localparam int PW = VALUE_WIDTH + CFG_W;          // product width
   localparam int AW = $clog2(MAX_DIGITS);           // digit store address
   localparam int CW = $clog2(MAX_DIGITS + 1);       // digit count
   localparam int SW = $clog2(VALUE_WIDTH);          // divider step count

   function automatic logic [CFG_W-1:0] clamp_base(input logic [CFG_W-1:0] b);
      logic [CFG_W-1:0] r;
      r = b;
      if (b < BASE_MIN) r = BASE_MIN;
      if (b > BASE_MAX) r = BASE_MAX;
      return r;
   endfunction

   function automatic logic [DIGIT_W-1:0] char_value(input logic [7:0] c);
      logic [DIGIT_W-1:0] r;
      r = NOT_A_DIGIT;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         r = DIGIT_W'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         r = DIGIT_W'(c - CHAR_UPPER_A + 8'd10);
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         r = DIGIT_W'(c - CHAR_LOWER_A + 8'd10);
      end
      return r;
   endfunction

   function automatic logic [7:0] value_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] r;
      if (d < DIGIT_W'(10)) r = CHAR_ZERO + 8'(d);
      else                  r = CHAR_UPPER_A + 8'(d) - 8'd10;
      return r;
   endfunction

   // base registers
   logic [CFG_W-1:0] in_base_ff, out_base_ff;
   logic [CFG_W-1:0] ib, ob;

   // number state
   logic [VALUE_WIDTH-1:0] acc_ff;
   logic                   bad_ff, ovf_ff;
   logic [PW-1:0]          prod_ff;
   logic [DIGIT_W-1:0]     digit_ff;
   logic                   end_ff;
   logic [PW:0]            sum;

   // divider
   logic [VALUE_WIDTH-1:0] q_ff;
   logic [DIGIT_W-1:0]     rem_ff;
   logic [SW-1:0]          step_ff;
   logic [DIGIT_W:0]       rem_cat;
   logic                   rem_ge;

   // digit store
   logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];
   logic [CW-1:0]          count_ff;
   logic [AW-1:0]          rd_idx_ff;
   logic [DIGIT_W-1:0]     rd_data_ff;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   logic                   out_free;

   assign ib = clamp_base(in_base_ff);
   assign ob = clamp_base(out_base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_base_ff  <= BASE_RESET;
         out_base_ff <= BASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IN_BASE:  in_base_ff  <= csr_wdata;
            CSR_OUT_BASE: out_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture: product of accumulator and base, digit value of the character
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prod_ff  <= PW'(acc_ff) * PW'(ib);
         digit_ff <= char_value(req_data.digit_char);
         end_ff   <= req_data.end_of_number;
      end
   end

   assign sum = (PW + 1)'(prod_ff) + (PW + 1)'(digit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (cmd.clear) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (cmd.fold) begin
         if (digit_ff >= ib) begin
            bad_ff <= 1'b1;
         end else if (!ovf_ff) begin
            if (|sum[PW:VALUE_WIDTH]) begin
               ovf_ff <= 1'b1;
            end else begin
               acc_ff <= sum[VALUE_WIDTH-1:0];
            end
         end
      end
   end

   // restoring division by out_base, one quotient bit per step
   assign rem_cat = {rem_ff, q_ff[VALUE_WIDTH-1]};
   assign rem_ge  = (rem_cat >= {1'b0, ob});

   always_ff @(posedge clock) begin
      if (cmd.div_load || cmd.div_restart) begin
         if (cmd.div_load) q_ff <= acc_ff;
         rem_ff  <= '0;
         step_ff <= SW'(VALUE_WIDTH - 1);
      end else if (cmd.div_step) begin
         q_ff    <= {q_ff[VALUE_WIDTH-2:0], rem_ge};
         rem_ff  <= rem_ge ? DIGIT_W'(rem_cat - {1'b0, ob}) : rem_cat[DIGIT_W-1:0];
         step_ff <= step_ff - SW'(1);
      end
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         digit_mem[count_ff[AW-1:0]] <= rem_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= digit_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear || cmd.div_load) begin
         count_ff <= '0;
      end else if (cmd.store_digit) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         rd_idx_ff <= count_ff[AW-1:0];
      end else if (cmd.push_digit && rd_idx_ff != '0) begin
         rd_idx_ff <= rd_idx_ff - AW'(1);
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push_digit || cmd.push_error) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_digit) begin
         rsp_ff.out_char   <= value_char(rd_data_ff);
         rsp_ff.last_digit <= (rd_idx_ff == '0);
         rsp_ff.status     <= STATUS_OK;
      end else if (cmd.push_error) begin
         rsp_ff.out_char   <= CHAR_NONE;
         rsp_ff.last_digit <= 1'b1;
         rsp_ff.status     <= bad_ff ? STATUS_BAD_DIGIT : STATUS_OVERFLOW;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.end_flag   = end_ff;
   assign stat.bad_seen   = bad_ff;
   assign stat.ovf_seen   = ovf_ff;
   assign stat.div_last   = (step_ff == '0);
   assign stat.quot_zero  = (q_ff == '0);
   assign stat.count_full = (count_ff == CW'(MAX_DIGITS - 1));
   assign stat.rd_last    = (rd_idx_ff == '0);
   assign stat.out_free   = out_free;

`ifndef SYNTH
   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < ob)
      else $error("division remainder not below output base");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_error || (cmd.push_digit && rd_idx_ff == '0))
      |=> (count_ff == '0) && !bad_ff && !ovf_ff && (acc_ff == '0))
      else $error("number state not cleared after last item");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store_digit |-> count_ff < CW'(MAX_DIGITS))
      else $error("digit store written beyond its depth");
`endif

endmodule

>>> design/radix_string_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_converter_top: ASCII radix converter, bases 2 to 36
// Folds digit characters of in_base into an accumulator and emits the value
// as upper-case digit characters of out_base, most significant first.
// ----------------------------------------------------------------------------
// Each input item is one ASCII digit character (0-9, A-Z or a-z), most
// significant first; end_of_number marks the final one. Each character is
// captured while accumulator * in_base is formed in the multiplier, then
// the fold step adds the digit and checks for overflow. Characters that
// do not end a number give no result. At the end of a number the block
// does the error check, then per output digit runs the bit-serial
// restoring divider (one quotient bit a cycle) and a store into the digit
// store; it then reads each digit back from the digit store and loads the
// output register with it; rsp_stall holds the output register and so
// pauses the read-back. No new item is taken until the last result of a
// number sits in the output register; that item then waits there while
// the next number streams in. An invalid character (not alphanumeric, or
// not below in_base) or an accumulator overflow turns the number into one
// item with out_char 0, last_digit 1 and status 1 or 2, invalid digit
// first; so does a value that needs more than MAX_DIGITS digits. Zero is
// emitted as '0'. Base registers below 2 act as 2, above 36 as 36; write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module radix_string_converter_top #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAX_DIGITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_we,
   input  logic [rsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsc_pkg::CFG_W-1:0]     csr_wdata,
   // input items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rsc_pkg::req_type              req_data,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsc_pkg::rsp_type              rsp_data
);
   import rsc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: capture, fold, check, divide, store, read back, push or error
   rsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // accumulator, divider, digit store and output register
   rsc_dp #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
